[hdl/sfr_pkg.sv]
// Shared types, constants and codes for the serial frame receiver.
package sfr_pkg;

    // Largest payload in bytes; the checksum byte comes on top of it.
    localparam int PAYLOAD_MAX = 32;
    // Payload counters are six bits wide, which covers any payload limit up to 63.
    localparam int CNT_W = 6;
    localparam int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    // Result status codes.
    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_BAD_MARKERS = 3'd1;
    localparam logic [2:0] STAT_TOO_LONG    = 3'd2;
    localparam logic [2:0] STAT_BAD_SUM     = 3'd3;
    localparam logic [2:0] STAT_TIMEOUT     = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_MARKER  = 2'd0;
    localparam logic [1:0] CFG_END_MARKER    = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  START_MARKER_RST  = 8'd170;
    localparam logic [7:0]  END_MARKER_RST    = 8'd85;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

    // Request type of an input item.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // One input item.
    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } sfr_in_t;

    // One result item.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] opcode;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic [4:0]  byte_index;
        logic        last;
    } sfr_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       hdr_wr;
        logic       pay_start;
        logic       pay_wr;
        logic       tick_inc;
        logic       emit_start;
        logic       emit_step;
        logic       stat_load;
        logic [2:0] stat_code;
    } sfr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hdr_last;
        logic markers_ok;
        logic len_ok;
        logic pay_more;
        logic sum_ok;
        logic timed_out;
        logic plen_zero;
        logic emit_last;
        logic out_free;
    } sfr_stat_t;

endpackage

[hdl/sfr_ctrl.sv]
// Controller state machine of the serial frame receiver.
module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rx_valid,
    input  logic      req_type,
    input  sfr_stat_t stat,
    output logic      rx_stall,
    output sfr_cmd_t  cmd
);

    localparam logic [1:0] ST_HEADER  = 2'd0;
    localparam logic [1:0] ST_PAYLOAD = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rx_fire;

    // Input is held off while a frame is played out or the result register is blocked.
    assign rx_stall = (state_reg == ST_EMIT) || !stat.out_free;
    assign rx_fire  = rx_valid && !rx_stall;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.stat_code = STAT_OK;
        unique case (state_reg)
            ST_HEADER:
            begin
                if (rx_fire && req_type == REQ_BYTE)
                begin
                    cmd.hdr_wr = 1'b1;
                    if (stat.hdr_last)
                    begin
                        if (!stat.markers_ok)
                        begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = STAT_BAD_MARKERS;
                        end
                        else if (!stat.len_ok)
                        begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = STAT_TOO_LONG;
                        end
                        else
                        begin
                            cmd.pay_start = 1'b1;
                            state_next    = ST_PAYLOAD;
                        end
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (rx_fire)
                begin
                    if (req_type == REQ_TICK)
                    begin
                        if (stat.timed_out)
                        begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = STAT_TIMEOUT;
                            state_next    = ST_HEADER;
                        end
                        else
                        begin
                            cmd.tick_inc = 1'b1;
                        end
                    end
                    else if (stat.pay_more)
                    begin
                        cmd.pay_wr = 1'b1;
                    end
                    else if (!stat.sum_ok)
                    begin
                        cmd.stat_load = 1'b1;
                        cmd.stat_code = STAT_BAD_SUM;
                        state_next    = ST_HEADER;
                    end
                    else if (stat.plen_zero)
                    begin
                        // An empty frame is reported by one status item.
                        cmd.stat_load = 1'b1;
                        cmd.stat_code = STAT_OK;
                        state_next    = ST_HEADER;
                    end
                    else
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = ST_HEADER;
                    end
                end
            end
            default:
            begin
                state_next = ST_HEADER;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A payload byte is only stored while the frame is in the payload phase.
    a_pay_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pay_wr |-> state_reg == ST_PAYLOAD)
        else $error("payload write outside payload phase");

    // Leaving the emit state happens only on the last payload byte.
    a_emit_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next != ST_EMIT) |-> (cmd.emit_step && stat.emit_last))
        else $error("emit ended early");

    // A frame starts its playout only as a good checksum byte is taken.
    a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_start |-> (rx_fire && stat.sum_ok && !stat.plen_zero))
        else $error("emit started without a good frame");

endmodule

[hdl/sfr_dp.sv]
// Datapath of the serial frame receiver: configuration, header, payload buffer, counters, result register.
module sfr_dp
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sfr_in_t     rx_item,
    input  sfr_cmd_t    cmd,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        res_stall,
    output sfr_stat_t   stat,
    output logic        res_valid,
    output sfr_out_t    res_item
);

    logic [7:0]       start_marker_reg;
    logic [7:0]       end_marker_reg;
    logic [15:0]      timeout_ticks_reg;
    logic [2:0]       header_count_reg;
    logic [63:0]      header_store_reg;
    logic [7:0]       payload_store_reg [PAYLOAD_MAX];
    logic [CNT_W-1:0] payload_count_reg;
    logic [7:0]       running_sum_reg;
    logic [15:0]      wait_ticks_reg;
    logic [CNT_W-1:0] emit_idx_reg;
    logic             res_valid_reg;
    sfr_out_t         res_item_reg;
    logic [15:0]      plen;
    logic [7:0]       sum_neg;

    // Payload length without the checksum byte, taken modulo 2^16.
    assign plen    = header_store_reg[55:40] - 16'd1;
    assign sum_neg = 8'd0 - running_sum_reg;

    // Status toward the controller.
    always_comb
    begin
        stat.hdr_last   = (header_count_reg == 3'd7);
        stat.markers_ok = (header_store_reg[7:0] == start_marker_reg)
                          && (rx_item.rx_byte == end_marker_reg);
        stat.len_ok     = (plen <= 16'(PAYLOAD_MAX));
        stat.pay_more   = (16'(payload_count_reg) < plen);
        stat.sum_ok     = (rx_item.rx_byte == sum_neg);
        stat.timed_out  = (wait_ticks_reg >= timeout_ticks_reg);
        stat.plen_zero  = (plen == 16'd0);
        stat.emit_last  = ((16'(emit_idx_reg) + 16'd1) == plen);
        stat.out_free   = !res_valid_reg || !res_stall;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg  <= START_MARKER_RST;
            end_marker_reg    <= END_MARKER_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_MARKER:  start_marker_reg  <= cfg_data[7:0];
                CFG_END_MARKER:    end_marker_reg    <= cfg_data[7:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Header collection, payload counters, tick counter and playout index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg  <= '0;
            header_store_reg  <= '0;
            payload_count_reg <= '0;
            running_sum_reg   <= '0;
            wait_ticks_reg    <= '0;
            emit_idx_reg      <= '0;
        end
        else
        begin
            if (cmd.hdr_wr)
            begin
                header_store_reg[{header_count_reg, 3'b000} +: 8] <= rx_item.rx_byte;
                header_count_reg <= header_count_reg + 3'd1;
            end
            if (cmd.pay_start)
            begin
                payload_count_reg <= '0;
                running_sum_reg   <= '0;
                wait_ticks_reg    <= '0;
            end
            if (cmd.pay_wr)
            begin
                payload_count_reg <= payload_count_reg + CNT_W'(1);
                running_sum_reg   <= running_sum_reg + rx_item.rx_byte;
            end
            if (cmd.tick_inc)
            begin
                wait_ticks_reg <= wait_ticks_reg + 16'd1;
            end
            if (cmd.emit_start)
            begin
                emit_idx_reg <= '0;
            end
            else if (cmd.emit_step)
            begin
                emit_idx_reg <= emit_idx_reg + CNT_W'(1);
            end
        end
    end

    // Payload buffer.
    always_ff @(posedge clk)
    begin
        if (cmd.pay_wr)
        begin
            payload_store_reg[payload_count_reg[IDX_W-1:0]] <= rx_item.rx_byte;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= cmd.emit_step || cmd.stat_load || (res_valid_reg && res_stall);
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_step)
        begin
            res_item_reg.status     <= STAT_OK;
            res_item_reg.opcode     <= header_store_reg[23:8];
            res_item_reg.address    <= header_store_reg[39:24];
            res_item_reg.data_byte  <= payload_store_reg[emit_idx_reg[IDX_W-1:0]];
            res_item_reg.data_valid <= 1'b1;
            res_item_reg.byte_index <= 5'(emit_idx_reg);
            res_item_reg.last       <= stat.emit_last;
        end
        else if (cmd.stat_load)
        begin
            res_item_reg.status     <= cmd.stat_code;
            res_item_reg.opcode     <= header_store_reg[23:8];
            res_item_reg.address    <= header_store_reg[39:24];
            res_item_reg.data_byte  <= 8'd0;
            res_item_reg.data_valid <= 1'b0;
            res_item_reg.byte_index <= 5'd0;
            res_item_reg.last       <= 1'b1;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // The result register is only loaded when it is empty or being emptied.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_step || cmd.stat_load) |-> stat.out_free)
        else $error("result register overwritten");

    // A stored payload byte never lands outside the buffer.
    a_pay_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pay_wr |-> (payload_count_reg < CNT_W'(PAYLOAD_MAX)))
        else $error("payload buffer overrun");

    // A status item never carries a payload byte.
    a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.status != STAT_OK) |-> (!res_item.data_valid && res_item.last))
        else $error("status item carries data");

    // The last payload byte of a frame closes the run.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_step && stat.emit_last) |=> (res_valid && res_item.last))
        else $error("run not closed");

endmodule

[hdl/serial_frame_receiver.sv]
// Top level of the serial frame receiver.
//
// The block takes received bytes and millisecond ticks, one item per cycle while it is
// collecting a frame and its result register is not blocked: an 8-byte header (start
// marker, opcode, address and length, all little-endian, then end marker), then the
// payload and a checksum byte that must equal the negated 8-bit sum of the payload. A
// good frame is played out from a 32-entry payload buffer as one result per payload
// byte (one status result if empty), one per cycle while the result side does not
// stall, and input is stalled during playout. A bad marker, an overlong length, a bad
// checksum or a timeout (more ticks than timeout_ticks after the header) drops the
// frame with one status result. Configuration registers: 0 start_marker, 1 end_marker,
// 2 timeout_ticks; write them only while no frame is in progress.
module serial_frame_receiver
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  sfr_in_t     rx_item,
    output logic        res_valid,
    input  logic        res_stall,
    output sfr_out_t    res_item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    sfr_cmd_t  cmd;
    sfr_stat_t stat;

    // Frame sequencing.
    sfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .req_type (rx_item.req_type),
        .stat     (stat),
        .rx_stall (rx_stall),
        .cmd      (cmd)
    );

    // Storage, checks and result register.
    sfr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_item   (rx_item),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_stall (res_stall),
        .stat      (stat),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

endmodule

[bench/sfr_checker.sv]
// Watches both channels of the serial frame receiver, predicts its results and checks them.
`timescale 1ns / 100ps

module sfr_checker
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    input  logic        rx_stall,
    input  sfr_in_t     rx_item,
    input  logic        res_valid,
    input  logic        res_stall,
    input  sfr_out_t    res_item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_total,
    output int          results_owed,
    output logic        frame_idle
);

    typedef enum logic {COLLECT_HEADER, COLLECT_PAYLOAD} rx_phase_t;

    // Predicted state of the receiver.
    rx_phase_t        phase;
    logic [2:0]       hdr_count;
    logic [63:0]      hdr_bytes;
    logic [7:0]       payload_mem [PAYLOAD_MAX];
    logic [CNT_W-1:0] payload_count;
    logic [7:0]       byte_sum;
    logic [15:0]      tick_count;

    // Shadow copies of the configuration registers.
    logic [7:0]       start_mark;
    logic [7:0]       end_mark;
    logic [15:0]      tick_limit;

    // Results the block still owes, oldest first.
    sfr_out_t         owed_results [$];

    // The stimulus side may only reconfigure on a frame boundary.
    assign frame_idle = (phase == COLLECT_HEADER) && (hdr_count == 3'd0);

    // Queues one result that carries the opcode and address of the current header.
    task automatic owe_result(input logic [2:0] code, input logic [7:0] data,
                              input logic valid, input logic [4:0] idx, input logic fin);
        sfr_out_t r;
        r.status     = code;
        r.opcode     = hdr_bytes[8 +: 16];
        r.address    = hdr_bytes[24 +: 16];
        r.data_byte  = data;
        r.data_valid = valid;
        r.byte_index = idx;
        r.last       = fin;
        owed_results.push_back(r);
    endtask

    // Drops the current frame with a single status result.
    task automatic drop_frame(input logic [2:0] code);
        owe_result(code, 8'h00, 1'b0, 5'd0, 1'b1);
        phase     = COLLECT_HEADER;
        hdr_count = 3'd0;
    endtask

    // Advances the predicted state by one accepted input item.
    task automatic absorb_item(input sfr_in_t it);
        logic [15:0] plen;
        logic [7:0]  want_sum;
        int          i;
        plen     = hdr_bytes[40 +: 16] - 16'd1;
        want_sum = 8'h00 - byte_sum;
        if (phase == COLLECT_HEADER)
        begin
            // Ticks mean nothing until a header has been taken.
            if (it.req_type == REQ_TICK)
                return;
            hdr_bytes[8*hdr_count +: 8] = it.rx_byte;
            if (hdr_count != 3'd7)
            begin
                hdr_count = hdr_count + 3'd1;
                return;
            end
            hdr_count = 3'd0;
            plen      = hdr_bytes[40 +: 16] - 16'd1;
            if (hdr_bytes[7:0] != start_mark || hdr_bytes[63:56] != end_mark)
                drop_frame(STAT_BAD_MARKERS);
            else if (plen > PAYLOAD_MAX)
                drop_frame(STAT_TOO_LONG);
            else
            begin
                phase         = COLLECT_PAYLOAD;
                payload_count = '0;
                byte_sum      = 8'h00;
                tick_count    = 16'd0;
            end
        end
        else if (it.req_type == REQ_TICK)
        begin
            // A tick past the allowance drops the frame.
            if (tick_count >= tick_limit)
                drop_frame(STAT_TIMEOUT);
            else
                tick_count = tick_count + 16'd1;
        end
        else if (payload_count < plen && payload_count < PAYLOAD_MAX)
        begin
            payload_mem[payload_count[IDX_W-1:0]] = it.rx_byte;
            payload_count                         = payload_count + CNT_W'(1);
            byte_sum                              = byte_sum + it.rx_byte;
        end
        else if (it.rx_byte != want_sum)
        begin
            drop_frame(STAT_BAD_SUM);
        end
        else
        begin
            // Good frame: one result per payload byte, or one empty result.
            phase     = COLLECT_HEADER;
            hdr_count = 3'd0;
            if (plen == 16'd0)
                owe_result(STAT_OK, 8'h00, 1'b0, 5'd0, 1'b1);
            else
                for (i = 0; i < plen; i++)
                    owe_result(STAT_OK, payload_mem[IDX_W'(i)], 1'b1, 5'(i), (i + 1) == plen);
        end
    endtask

    // Reports one field that differs from its prediction.
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_total++;
        end
    endtask

    // Compares an accepted result with the oldest owed one.
    task automatic compare_result(input sfr_out_t got);
        sfr_out_t want;
        if (owed_results.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, got %h", $time, got);
            fail_total++;
            return;
        end
        want = owed_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("opcode", want.opcode, got.opcode);
        check_field("address", want.address, got.address);
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("data_valid", want.data_valid, got.data_valid);
        check_field("byte_index", want.byte_index, got.byte_index);
        check_field("last", want.last, got.last);
    endtask

    // Samples the configuration port and both channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase         = COLLECT_HEADER;
            hdr_count     = 3'd0;
            hdr_bytes     = 64'd0;
            payload_count = '0;
            byte_sum      = 8'h00;
            tick_count    = 16'd0;
            start_mark    = START_MARKER_RST;
            end_mark      = END_MARKER_RST;
            tick_limit    = TIMEOUT_TICKS_RST;
            owed_results.delete();
            fail_total    = 0;
            results_owed  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_MARKER:  start_mark = cfg_data[7:0];
                    CFG_END_MARKER:    end_mark   = cfg_data[7:0];
                    CFG_TIMEOUT_TICKS: tick_limit = cfg_data;
                    default: ;
                endcase
            end
            if (rx_valid && !rx_stall)
                absorb_item(rx_item);
            if (res_valid && !res_stall)
                compare_result(res_item);
            results_owed = owed_results.size();
        end
    end

endmodule

[bench/tb_serial_frame_receiver.sv]
// Stimulus and verdict for the serial frame receiver, with the result checker beside it.
`timescale 1ns / 100ps

module tb_serial_frame_receiver;
    import sfr_pkg::*;

    // Index past the register list; writes to it must change nothing.
    localparam logic [1:0] CFG_SPARE = 2'd3;
    // Cycles the block may still need after its last owed result.
    localparam int DRAIN_CYCLES = 48;
    // Length of the single long hold-off on the result side.
    localparam int HOLD_CYCLES = 150;

    typedef enum int {FLAW_NONE, FLAW_START, FLAW_END, FLAW_LENGTH, FLAW_SUM,
                      FLAW_TIMEOUT} flaw_t;

    logic        clk;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_stall;
    sfr_in_t     rx_item;
    logic        res_valid;
    logic        res_stall;
    sfr_out_t    res_item;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int          fail_total;
    int          results_owed;
    logic        frame_idle;

    // Stimulus bookkeeping and the current register settings.
    int          items_sent = 0;
    bit          quiet = 1'b0;
    bit          hold_go = 1'b0;
    bit          hold_done = 1'b0;
    logic [7:0]  cur_start;
    logic [7:0]  cur_end;
    logic [15:0] cur_timeout;

    serial_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_item   (rx_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sfr_checker frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_item      (rx_item),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .res_item     (res_item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_total   (fail_total),
        .results_owed (results_owed),
        .frame_idle   (frame_idle)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result-side stalls: random short bursts, plus one long hold when asked.
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                res_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Ends a hung run.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offers one item, after an optional gap, and returns at the falling edge after it is taken.
    task automatic send_item(input logic rt, input logic [7:0] b, input bit counted);
        sfr_in_t it;
        it.req_type = rt;
        it.rx_byte  = b;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_item  <= it;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        @(negedge clk);
        if (counted)
            items_sent++;
    endtask

    // Sends the eight header bytes, with the odd ignored tick in between.
    task automatic send_header(input logic [7:0] s, input logic [15:0] op,
                               input logic [15:0] addr, input logic [15:0] len,
                               input logic [7:0] e);
        logic [63:0] h;
        int          k;
        h = {e, len, addr, op, s};
        for (k = 0; k < 8; k++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(REQ_TICK, 8'($urandom), 1'b0);
            send_item(REQ_BYTE, h[8*k +: 8], 1'b1);
        end
    endtask

    // Sends one frame with random content and at most one deliberate flaw.
    task automatic send_frame(input flaw_t flaw);
        int          n;
        int          k;
        int          i;
        int          spent;
        int          r;
        logic [15:0] len;
        logic [7:0]  s;
        logic [7:0]  e;
        logic [7:0]  b;
        logic [7:0]  sum;
        logic [7:0]  chk;
        // Mostly short payloads, now and then a long or full one.
        r = $urandom_range(0, 19);
        if (r < 13)
            n = $urandom_range(0, 6);
        else if (r < 18)
            n = $urandom_range(7, PAYLOAD_MAX - 1);
        else
            n = PAYLOAD_MAX;
        len = 16'(n + 1);
        s   = cur_start;
        e   = cur_end;
        if (flaw == FLAW_START)
            s = s ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_END)
            e = e ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_LENGTH)
        begin
            r = $urandom_range(0, 2);
            if (r == 0)
                len = 16'd0;
            else if (r == 1)
                len = 16'(PAYLOAD_MAX + 2);
            else
                len = 16'($urandom_range(PAYLOAD_MAX + 2, 65535));
        end
        send_header(s, 16'($urandom), 16'($urandom), len, e);
        if (flaw == FLAW_START || flaw == FLAW_END || flaw == FLAW_LENGTH)
            return;

        // Payload and checksum, with ticks kept inside the allowance unless timing out.
        k     = (flaw == FLAW_TIMEOUT) ? $urandom_range(0, n) : -1;
        sum   = 8'h00;
        spent = 0;
        for (i = 0; i <= n; i++)
        begin
            if (i == k)
            begin
                repeat (int'(cur_timeout) - spent + 1)
                    send_item(REQ_TICK, 8'($urandom), 1'b1);
                return;
            end
            if (spent < int'(cur_timeout) && $urandom_range(0, 7) == 0)
            begin
                send_item(REQ_TICK, 8'($urandom), 1'b1);
                spent++;
            end
            if (i < n)
            begin
                b   = 8'($urandom);
                sum = sum + b;
                send_item(REQ_BYTE, b, 1'b1);
            end
            else
            begin
                chk = 8'h00 - sum;
                if (flaw == FLAW_SUM)
                    chk = chk ^ 8'($urandom_range(1, 255));
                send_item(REQ_BYTE, chk, 1'b1);
            end
        end
    endtask

    // Feeds zero bytes until the receiver is back at a frame boundary.
    task automatic flush_frame();
        while (!frame_idle)
            send_item(REQ_BYTE, 8'h00, 1'b1);
    endtask

    // Brings the receiver to rest: frame boundary, input withdrawn, nothing owed, drained.
    task automatic settle_block();
        flush_frame();
        rx_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Writes one register; the enable drops between writes.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Reconfigures at rest, then runs a mix of good, flawed and garbled frames.
    task automatic run_phase(input logic [7:0] s, input logic [7:0] e,
                             input logic [15:0] t, input int n, input bit with_hold);
        int quota;
        int pick;
        settle_block();
        write_reg(CFG_START_MARKER, {8'h00, s});
        write_reg(CFG_END_MARKER, {8'h00, e});
        write_reg(CFG_TIMEOUT_TICKS, t);
        write_reg(CFG_SPARE, 16'($urandom));
        cur_start   = s;
        cur_end     = e;
        cur_timeout = t;
        if (with_hold)
            hold_go = 1'b1;
        quota = items_sent + n;
        while (items_sent < quota)
        begin
            pick = $urandom_range(0, 24);
            if (pick == 0)
            begin
                // Garbage bytes and ticks, then back to a frame boundary.
                repeat ($urandom_range(1, 12))
                    send_item(1'($urandom), 8'($urandom), 1'b1);
                flush_frame();
            end
            else if (pick < 16)
                send_frame(FLAW_NONE);
            else if (pick < 18)
                send_frame(FLAW_START);
            else if (pick < 20)
                send_frame(FLAW_END);
            else if (pick < 22)
                send_frame(FLAW_LENGTH);
            else if (pick < 24)
                send_frame(FLAW_SUM);
            else if (cur_timeout <= 16'd8)
                send_frame(FLAW_TIMEOUT);
            else
                send_frame(FLAW_NONE);
        end
    endtask

    // Main sequence: reset, directed frames, then randomized phases.
    initial
    begin
        rst_n       = 1'b0;
        rx_valid    = 1'b0;
        rx_item     = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_START_MARKER;
        cfg_data    = 16'd0;
        cur_start   = START_MARKER_RST;
        cur_end     = END_MARKER_RST;
        cur_timeout = TIMEOUT_TICKS_RST;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: ignored tick, empty frame, bad end marker, zero length.
        send_item(REQ_TICK, 8'hFF, 1'b0);
        send_header(cur_start, 16'hFFFF, 16'h0000, 16'd1, cur_end);
        send_item(REQ_BYTE, 8'h00, 1'b1);
        send_header(cur_start, 16'h0000, 16'hFFFF, 16'd1, ~cur_end);
        send_header(cur_start, 16'h5A3C, 16'hC3A5, 16'd0, cur_end);

        // Randomized phases over several register settings.
        run_phase(8'h00, 8'hFF, 16'd0, 60, 1'b0);
        run_phase(8'hFF, 8'h00, 16'hFFFF, 60, 1'b1);
        run_phase(8'($urandom), 8'($urandom), 16'd5, 60, 1'b0);
        quiet = 1'b1;
        run_phase(START_MARKER_RST, END_MARKER_RST, TIMEOUT_TICKS_RST, 60, 1'b0);

        settle_block();
        if (fail_total == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
